/* hdl/fifo_with_remove_by_key_defines.svh */
// Assertion macros shared by the queue with removal by key.
// Depends on nothing; taken in by the modules that carry assertions.
`ifndef FIFO_WITH_REMOVE_BY_KEY_DEFINES_SVH
`define FIFO_WITH_REMOVE_BY_KEY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWRK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwrk assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FWRK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwrk assertion failed");

`endif

/* hdl/fwrk_pkg.sv */
// Shared types, field widths and codes of the queue with removal by key.
// Depends on nothing; used by fwrk_cell and fifo_with_remove_by_key.
`timescale 1ns / 1ps

package fwrk_pkg;

  localparam int IDENT_W      = 32;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 6;
  localparam int TDATA_W      = 40;
  localparam int OCC_MAX_W    = 7;
  localparam int DEPTH_DEF    = 32;
  localparam int ID_WIDTH_DEF = 32;

  typedef logic [IDENT_W-1:0]   ident_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [OCC_MAX_W-1:0] occ_t;

  localparam kind_t KIND_ENQ  = 2'd0;
  localparam kind_t KIND_REM  = 2'd1;
  localparam kind_t KIND_DUMP = 2'd2;

  localparam status_t ST_ENQUEUED   = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_REMOVED    = 3'd2;
  localparam status_t ST_NOT_FOUND  = 3'd3;
  localparam status_t ST_DUMP_ENTRY = 3'd4;
  localparam status_t ST_DUMP_EMPTY = 3'd5;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t CELL_HOLD   = 2'd0;
  localparam cell_op_t CELL_PUSH   = 2'd1;
  localparam cell_op_t CELL_REMOVE = 2'd2;
  localparam cell_op_t CELL_ROTATE = 2'd3;

  typedef struct packed {
    cell_op_t op;
    occ_t     occ;
  } cell_ctrl_t;

endpackage

/* hdl/fwrk_cell.sv */
// One storage cell of the queue chain: holds an entry, compares it with the key
// and takes data from its right-hand neighbour when the chain closes up or rotates.
// Depends on fwrk_pkg.
`timescale 1ns / 1ps

module fwrk_cell #(
  parameter int ID_WIDTH = fwrk_pkg::ID_WIDTH_DEF,
  parameter int IDX      = 0
) (
  input  logic                 clk,
  input  fwrk_pkg::cell_ctrl_t ctrl,
  input  logic [ID_WIDTH-1:0]  key,
  input  logic [ID_WIDTH-1:0]  right_data,
  input  logic [ID_WIDTH-1:0]  head_data,
  input  logic                 hit_in,
  output logic                 hit_out,
  output logic [ID_WIDTH-1:0]  data
);

  localparam fwrk_pkg::occ_t MY_IDX   = fwrk_pkg::occ_t'(IDX);
  localparam fwrk_pkg::occ_t NEXT_IDX = fwrk_pkg::occ_t'(IDX + 1);

  logic [ID_WIDTH-1:0] data_r;
  logic [ID_WIDTH-1:0] data_nxt;
  logic                cell_valid;
  logic                match;

  assign cell_valid = MY_IDX < ctrl.occ;
  assign match      = cell_valid && (data_r == key);
  assign hit_out    = hit_in | match;
  assign data       = data_r;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      fwrk_pkg::CELL_PUSH: begin
        if (MY_IDX == ctrl.occ) begin
          data_nxt = key;
        end
      end
      fwrk_pkg::CELL_REMOVE: begin
        if (hit_out) begin
          data_nxt = right_data;
        end
      end
      fwrk_pkg::CELL_ROTATE: begin
        if (NEXT_IDX == ctrl.occ) begin
          data_nxt = head_data;
        end else if (NEXT_IDX < ctrl.occ) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* hdl/fifo_with_remove_by_key.sv */
// An enqueue or remove result sits in the output register in the cycle after its transfer.
// Throughput: one enqueue or remove per cycle while results are taken; a dump of n entries
// gives n results, one a cycle while results are taken, once in the dump state, as the chain
// rotates its head to the tail; the next item is taken once the last dump result is registered.
// Reset: synchronous, active low; clears occupancy, sequencer and output valid, not the cells.
// Depends on fwrk_pkg, fwrk_cell and fifo_with_remove_by_key_defines.svh.
`timescale 1ns / 1ps
`include "fifo_with_remove_by_key_defines.svh"

module fifo_with_remove_by_key #(
  parameter int DEPTH    = fwrk_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = fwrk_pkg::ID_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [fwrk_pkg::IDENT_W-1:0] in_tdata,   // ident [31:0]
  input  logic [fwrk_pkg::KIND_W-1:0]  in_tuser,   // kind [1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [fwrk_pkg::TDATA_W-1:0] out_tdata,  // value [31:0], count [37:32], zeros [39:38]
  output logic [fwrk_pkg::STATUS_W-1:0] out_tuser, // status [2:0]
  output logic                         out_tlast
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0] ONE_OCC  = OCC_W'(1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                  state_r, state_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [OCC_W-1:0]      rem_r, rem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fwrk_pkg::status_t     out_status_r, out_status_nxt;
  fwrk_pkg::ident_t      out_value_r, out_value_nxt;
  fwrk_pkg::count_t      out_count_r, out_count_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  in_fire;
  logic [ID_WIDTH-1:0]   key;
  fwrk_pkg::cell_ctrl_t  ctrl;
  fwrk_pkg::cell_op_t    cell_op;
  logic [DEPTH:0]        hit;
  logic [ID_WIDTH-1:0]   data [DEPTH];
  logic                  found;
  fwrk_pkg::occ_t        occ_ext;
  fwrk_pkg::occ_t        occ_nxt_ext;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign key       = ID_WIDTH'(in_tdata);
  assign found     = hit[DEPTH];
  assign hit[0]    = 1'b0;
  assign occ_ext   = fwrk_pkg::occ_t'(occ_r);
  assign occ_nxt_ext = fwrk_pkg::occ_t'(occ_nxt);
  assign ctrl      = {cell_op, occ_ext};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] right;
    if (i == DEPTH - 1) begin : g_end
      assign right = data[i];
    end else begin : g_mid
      assign right = data[i+1];
    end
    fwrk_cell #(
      .ID_WIDTH (ID_WIDTH),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (key),
      .right_data (right),
      .head_data  (data[0]),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .data       (data[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    rem_nxt        = rem_r;
    cell_op        = fwrk_pkg::CELL_HOLD;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    if (in_fire) begin
      out_value_nxt = in_tdata;
      out_last_nxt  = 1'b1;
      case (in_tuser)
        fwrk_pkg::KIND_ENQ: begin
          out_valid_nxt = 1'b1;
          if (occ_r == FULL_OCC) begin
            out_status_nxt = fwrk_pkg::ST_FULL;
          end else begin
            cell_op        = fwrk_pkg::CELL_PUSH;
            occ_nxt        = occ_r + ONE_OCC;
            out_status_nxt = fwrk_pkg::ST_ENQUEUED;
          end
        end
        fwrk_pkg::KIND_REM: begin
          out_valid_nxt = 1'b1;
          cell_op       = fwrk_pkg::CELL_REMOVE;
          if (found) begin
            occ_nxt        = occ_r - ONE_OCC;
            out_status_nxt = fwrk_pkg::ST_REMOVED;
          end else begin
            out_status_nxt = fwrk_pkg::ST_NOT_FOUND;
          end
        end
        fwrk_pkg::KIND_DUMP: begin
          if (occ_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fwrk_pkg::ST_DUMP_EMPTY;
            out_value_nxt  = '0;
          end else begin
            state_nxt = ST_DUMP;
            rem_nxt   = occ_r;
          end
        end
        default: begin
          out_value_nxt = out_value_r;
          out_last_nxt  = out_last_r;
        end
      endcase
      out_count_nxt = occ_nxt_ext[fwrk_pkg::COUNT_W-1:0];
    end else if ((state_r == ST_DUMP) && out_free) begin
      cell_op        = fwrk_pkg::CELL_ROTATE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = fwrk_pkg::ST_DUMP_ENTRY;
      out_value_nxt  = fwrk_pkg::ident_t'(data[0]);
      out_count_nxt  = occ_ext[fwrk_pkg::COUNT_W-1:0];
      out_last_nxt   = (rem_r == ONE_OCC);
      rem_nxt        = rem_r - ONE_OCC;
      if (rem_r == ONE_OCC) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(fwrk_pkg::TDATA_W - fwrk_pkg::IDENT_W - fwrk_pkg::COUNT_W){1'b0}},
                       out_count_r, out_value_r};

  `FWRK_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_r <= FULL_OCC)
  `FWRK_ASSERT_IMP(a_dump_rem, clk, rst_n, state_r == ST_DUMP,
                   (rem_r != '0) && (rem_r <= occ_r))
  `FWRK_ASSERT_NXT(a_enq_grow, clk, rst_n,
                   in_fire && (in_tuser == fwrk_pkg::KIND_ENQ) && (occ_r != FULL_OCC),
                   occ_r == $past(occ_r) + ONE_OCC)
  `FWRK_ASSERT_NXT(a_rem_shrink, clk, rst_n,
                   in_fire && (in_tuser == fwrk_pkg::KIND_REM) && found,
                   occ_r == $past(occ_r) - ONE_OCC)
  `FWRK_ASSERT_IMP(a_hit_valid, clk, rst_n, found, occ_r != '0)

endmodule

/* sim/tb.sv */
// Self-checking bench for fifo_with_remove_by_key: enqueue, remove-by-key and dump transfers
// are predicted by a scoreboard class and every output transfer is compared field by field.
// Depends on fwrk_pkg and the RTL of fifo_with_remove_by_key.
`timescale 1ns / 1ps

module tb;

  localparam int              DEPTH       = fwrk_pkg::DEPTH_DEF;
  localparam fwrk_pkg::kind_t KIND_UNUSED = 2'd3;

  typedef struct packed {
    fwrk_pkg::status_t status;
    fwrk_pkg::ident_t  value;
    fwrk_pkg::count_t  count;
    logic              last;
  } result_t;

  class keyed_queue_sb;
    fwrk_pkg::ident_t held_ids[$];
    result_t          pending_results[$];
    int unsigned      bad_count;

    function new();
      bad_count = 0;
    endfunction

    function fwrk_pkg::ident_t pick_held();
      return held_ids[$urandom_range(held_ids.size() - 1)];
    endfunction

    function void note_item(fwrk_pkg::kind_t kind, fwrk_pkg::ident_t ident);
      result_t r;
      int      idx;
      idx = -1;
      case (kind)
        fwrk_pkg::KIND_ENQ: begin
          if (held_ids.size() >= DEPTH) begin
            r = '{fwrk_pkg::ST_FULL, ident, fwrk_pkg::count_t'(held_ids.size()), 1'b1};
          end else begin
            held_ids.push_back(ident);
            r = '{fwrk_pkg::ST_ENQUEUED, ident, fwrk_pkg::count_t'(held_ids.size()), 1'b1};
          end
          pending_results.push_back(r);
        end
        fwrk_pkg::KIND_REM: begin
          foreach (held_ids[i]) begin
            if (idx < 0 && held_ids[i] == ident) idx = i;
          end
          if (idx < 0) begin
            r = '{fwrk_pkg::ST_NOT_FOUND, ident, fwrk_pkg::count_t'(held_ids.size()), 1'b1};
          end else begin
            held_ids.delete(idx);
            r = '{fwrk_pkg::ST_REMOVED, ident, fwrk_pkg::count_t'(held_ids.size()), 1'b1};
          end
          pending_results.push_back(r);
        end
        fwrk_pkg::KIND_DUMP: begin
          if (held_ids.size() == 0) begin
            r = '{fwrk_pkg::ST_DUMP_EMPTY, '0, '0, 1'b1};
            pending_results.push_back(r);
          end else begin
            foreach (held_ids[i]) begin
              r = '{fwrk_pkg::ST_DUMP_ENTRY, held_ids[i],
                    fwrk_pkg::count_t'(held_ids.size()), (i == held_ids.size() - 1)};
              pending_results.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(fwrk_pkg::status_t status, fwrk_pkg::ident_t value,
                               fwrk_pkg::count_t count, logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected transfer: status %0d value %h count %0d last %b",
                   status, value, count, last);
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status || value !== want.value || count !== want.count ||
          last !== want.last) begin
        bad_count++;
        if (bad_count <= 10)
          $display("mismatch: expected status %0d value %h count %0d last %b, got %0d %h %0d %b",
                   want.status, want.value, want.count, want.last,
                   status, value, count, last);
      end
    endfunction
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [fwrk_pkg::IDENT_W-1:0]  in_tdata   = '0;
  logic [fwrk_pkg::KIND_W-1:0]   in_tuser   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [fwrk_pkg::TDATA_W-1:0]  out_tdata;
  logic [fwrk_pkg::STATUS_W-1:0] out_tuser;
  logic                          out_tlast;
  bit                            steady     = 1'b0;

  keyed_queue_sb queue_sb = new();

  fifo_with_remove_by_key #(
    .DEPTH   (DEPTH),
    .ID_WIDTH(fwrk_pkg::ID_WIDTH_DEF)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!steady && $urandom_range(99) < 9) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      queue_sb.check_result(out_tuser, out_tdata[31:0], out_tdata[37:32], out_tlast);
  end

  function automatic fwrk_pkg::ident_t pick_ident();
    case ($urandom_range(3))
      0, 1: return fwrk_pkg::ident_t'($urandom_range(7));
      2: return fwrk_pkg::ident_t'($urandom());
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  task automatic send_item(input fwrk_pkg::kind_t kind, input fwrk_pkg::ident_t ident);
    while (!steady && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= ident;
    do @(posedge clk); while (!in_tready);
    queue_sb.note_item(kind, ident);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (queue_sb.pending_results.size() != 0);
  endtask

  task automatic run_phase(input int n, input int enq_pct, input int rem_pct);
    int               roll;
    fwrk_pkg::kind_t  kind;
    fwrk_pkg::ident_t ident;
    for (int j = 0; j < n; j++) begin
      roll  = $urandom_range(99);
      ident = pick_ident();
      if (roll < enq_pct) begin
        kind = fwrk_pkg::KIND_ENQ;
      end else if (roll < enq_pct + rem_pct) begin
        kind = fwrk_pkg::KIND_REM;
        if (queue_sb.held_ids.size() != 0 && $urandom_range(9) < 7)
          ident = queue_sb.pick_held();
      end else if (roll < 97) begin
        kind = fwrk_pkg::KIND_DUMP;
      end else begin
        kind = KIND_UNUSED;
      end
      send_item(kind, ident);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(fwrk_pkg::KIND_DUMP, 32'h1234_5678);
    send_item(fwrk_pkg::KIND_REM, 32'h0000_0007);
    send_item(fwrk_pkg::KIND_ENQ, 32'h0000_0000);
    send_item(fwrk_pkg::KIND_ENQ, 32'h7FFF_FFFF);
    send_item(fwrk_pkg::KIND_ENQ, 32'h8000_0000);
    send_item(fwrk_pkg::KIND_ENQ, 32'hFFFF_FFFF);
    send_item(fwrk_pkg::KIND_ENQ, 32'h0000_0005);
    send_item(fwrk_pkg::KIND_ENQ, 32'h0000_0005);
    send_item(fwrk_pkg::KIND_DUMP, 32'hFFFF_FFFF);
    send_item(fwrk_pkg::KIND_REM, 32'h0000_0005);
    send_item(fwrk_pkg::KIND_REM, 32'h8000_0000);
    send_item(fwrk_pkg::KIND_REM, 32'h0000_0000);
    send_item(fwrk_pkg::KIND_REM, 32'h0000_0005);
    send_item(fwrk_pkg::KIND_REM, 32'h0000_1234);
    send_item(KIND_UNUSED, 32'h7FFF_FFFF);
    send_item(fwrk_pkg::KIND_DUMP, 32'h0000_0000);

    steady = 1'b1;
    run_phase(40, 88, 5);
    steady = 1'b0;
    run_phase(35, 20, 70);
    wait_for_results();
    run_phase(40, 88, 5);
    run_phase(35, 20, 70);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (queue_sb.bad_count == 0) begin
      $display("[fifo_with_remove_by_key] OK");
    end else begin
      $display("[fifo_with_remove_by_key] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[fifo_with_remove_by_key] ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/fwrk_pkg.sv
hdl/fwrk_cell.sv
hdl/fifo_with_remove_by_key.sv
sim/tb.sv
